[hw/rtl/tdp_pkg.sv]
// Package for the touchpad disable policy block.
// Holds the state and event codes, item types and depth helpers.
// Depends on nothing.
package tdp_pkg;

  localparam int TimerBitsDef = 16;
  localparam int TimeoutW     = 16;
  localparam int ApbAddrW     = 5;
  localparam int ApbDataW     = 32;

  typedef enum logic [1:0] {
    TP_ENABLED  = 2'd0,
    TP_DISABLED = 2'd1,
    TP_TAP_OFF  = 2'd2
  } tp_state_t;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_KB_START = 3'd1,
    ACT_KB_END   = 3'd2,
    ACT_MOUSE    = 3'd3,
    ACT_TOGGLE   = 3'd4,
    ACT_REPORT   = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    REG_KB_DISABLE  = 3'd0,
    REG_KB_TAP_ONLY = 3'd1,
    REG_MOUSE_DIS   = 3'd2,
    REG_KB_TIMEOUT  = 3'd3,
    REG_NOTIFY      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [2:0] action;
    logic       mouse_present;
    logic [1:0] reported_state;
    logic       confirmed;
  } in_item_t;

  typedef struct packed {
    logic [1:0] touchpad_state;
    logic       state_written;
    logic       enabled_changed;
    logic       notify;
    logic       need_confirm;
  } out_item_t;

  function automatic logic [1:0] depth_of(input logic [1:0] s);
    logic [1:0] d;
    unique case (s)
      TP_DISABLED: d = 2'd2;
      TP_TAP_OFF:  d = 2'd1;
      default:     d = 2'd0;
    endcase
    return d;
  endfunction

  function automatic logic deeper(input logic [1:0] a, input logic [1:0] b);
    return depth_of(a) > depth_of(b);
  endfunction

endpackage

[hw/rtl/touchpad_disable_policy.sv]
// Top level of the touchpad disable policy block.
// Uses tdp_pkg for codes, item types and the state depth helpers.
//
//   Port group   Handshake                 Carries
//   in_*         in_valid / in_ready       one event item
//   out_*        out_valid / out_ready     one result item per event
//   APB          psel / penable / pready   five policy registers
//
// An event is taken into an input register, evaluated combinationally and its
// result lands in the output register, so one item is taken every cycle while
// the output register is not stalled.
// The input register moves on whenever the output register is empty or
// being taken, so a stalled result stops new items only after one more.
// Reset is synchronous on rst_n low; it restores all state but the two item registers.
module touchpad_disable_policy
  import tdp_pkg::*;
#(
  parameter int TIMER_BITS = TimerBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_action,
  input  logic                in_mouse_present,
  input  logic [1:0]          in_reported_state,
  input  logic                in_confirmed,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_touchpad_state,
  output logic                out_state_written,
  output logic                out_enabled_changed,
  output logic                out_notify,
  output logic                out_need_confirm,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int LoadW = (TIMER_BITS > TimeoutW) ? TIMER_BITS : TimeoutW;

  logic                kb_dis_r, kb_tap_r, mouse_dis_r, notify_en_r;
  logic [TimeoutW-1:0] kb_tmo_r;

  logic       s1_valid_r, s1_adv;
  in_item_t   s1_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r, out_item_nxt;

  logic [1:0]            cur_r, cur_nxt;
  logic [1:0]            smouse_r, smouse_nxt;
  logic [1:0]            skb_r, skb_nxt;
  logic                  kba_r, kba_nxt;
  logic                  ma_r, ma_nxt;
  logic [TIMER_BITS-1:0] tcnt_r, tcnt_nxt;
  logic                  trun_r, trun_nxt;

  logic [LoadW-1:0]      tmo_ext, tmax_ext;
  logic [TIMER_BITS-1:0] load_val;
  logic [1:0]            kb_tgt;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kb_dis_r    <= 1'b1;
      kb_tap_r    <= 1'b1;
      mouse_dis_r <= 1'b0;
      kb_tmo_r    <= TimeoutW'(1000);
      notify_en_r <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_KB_DISABLE:  kb_dis_r    <= pwdata[0];
        REG_KB_TAP_ONLY: kb_tap_r    <= pwdata[0];
        REG_MOUSE_DIS:   mouse_dis_r <= pwdata[0];
        REG_KB_TIMEOUT:  kb_tmo_r    <= pwdata[TimeoutW-1:0];
        REG_NOTIFY:      notify_en_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_KB_DISABLE:  prdata = ApbDataW'(kb_dis_r);
      REG_KB_TAP_ONLY: prdata = ApbDataW'(kb_tap_r);
      REG_MOUSE_DIS:   prdata = ApbDataW'(mouse_dis_r);
      REG_KB_TIMEOUT:  prdata = ApbDataW'(kb_tmo_r);
      REG_NOTIFY:      prdata = ApbDataW'(notify_en_r);
      default:         prdata = '0;
    endcase
  end

  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= '{action: in_action, mouse_present: in_mouse_present,
                     reported_state: in_reported_state, confirmed: in_confirmed};
    end
    if (s1_adv && s1_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign tmo_ext  = LoadW'(kb_tmo_r);
  assign tmax_ext = LoadW'({TIMER_BITS{1'b1}});
  assign load_val = (tmo_ext > tmax_ext) ? tmax_ext[TIMER_BITS-1:0]
                                         : tmo_ext[TIMER_BITS-1:0];
  assign kb_tgt   = kb_tap_r ? TP_TAP_OFF : TP_DISABLED;

  always_comb begin
    logic       kb_go;
    logic [1:0] tgt;
    cur_nxt      = cur_r;
    smouse_nxt   = smouse_r;
    skb_nxt      = skb_r;
    kba_nxt      = kba_r;
    ma_nxt       = ma_r;
    tcnt_nxt     = tcnt_r;
    trun_nxt     = trun_r;
    out_item_nxt = '0;
    kb_go        = 1'b0;
    tgt          = cur_r;
    unique case (s1_item_r.action)
      ACT_TICK: begin
        if (trun_r) begin
          if (tcnt_r <= TIMER_BITS'(1)) begin
            tcnt_nxt = '0;
            trun_nxt = 1'b0;
            if (kba_r) begin
              kba_nxt = 1'b0;
              cur_nxt = skb_r;
              out_item_nxt.state_written = 1'b1;
            end
          end else begin
            tcnt_nxt = tcnt_r - TIMER_BITS'(1);
          end
        end
      end
      ACT_KB_START, ACT_KB_END: begin
        kb_go = !kba_r && kb_dis_r;
        if (kb_go) begin
          trun_nxt = 1'b0;
          kba_nxt  = 1'b1;
          skb_nxt  = cur_r;
          if (deeper(kb_tgt, cur_r)) begin
            cur_nxt = kb_tgt;
            out_item_nxt.state_written = 1'b1;
          end
        end
        if (s1_item_r.action == ACT_KB_END) begin
          tcnt_nxt = load_val;
          trun_nxt = 1'b1;
        end
      end
      ACT_MOUSE: begin
        ma_nxt = s1_item_r.mouse_present && mouse_dis_r;
        if (ma_nxt != ma_r) begin
          if (ma_nxt) begin
            smouse_nxt = kba_r ? cur_r : skb_r;
            tgt = deeper(cur_r, TP_DISABLED) ? cur_r : TP_DISABLED;
          end else begin
            tgt = deeper(smouse_r, cur_r) ? cur_r : smouse_r;
          end
          skb_nxt = tgt;
          if (!ma_nxt && kba_r && deeper(kb_tgt, tgt)) begin
            tgt = kb_tgt;
          end
          if (tgt != cur_r) begin
            cur_nxt = tgt;
            out_item_nxt.state_written = 1'b1;
            out_item_nxt.notify = ma_nxt && notify_en_r;
          end
        end
      end
      ACT_TOGGLE: begin
        if (cur_r == TP_ENABLED && !s1_item_r.mouse_present && !s1_item_r.confirmed) begin
          out_item_nxt.need_confirm = 1'b1;
        end else begin
          cur_nxt = (cur_r == TP_ENABLED) ? TP_DISABLED : TP_ENABLED;
          out_item_nxt.state_written = 1'b1;
        end
      end
      ACT_REPORT: begin
        if (s1_item_r.reported_state <= TP_TAP_OFF) begin
          cur_nxt = s1_item_r.reported_state;
        end
      end
      default: ;
    endcase
    out_item_nxt.touchpad_state  = cur_nxt;
    out_item_nxt.enabled_changed = (cur_r == TP_ENABLED) != (cur_nxt == TP_ENABLED);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= TP_ENABLED;
      smouse_r <= TP_ENABLED;
      skb_r    <= TP_ENABLED;
      kba_r    <= 1'b0;
      ma_r     <= 1'b0;
      tcnt_r   <= '0;
      trun_r   <= 1'b0;
    end else if (s1_adv && s1_valid_r) begin
      cur_r    <= cur_nxt;
      smouse_r <= smouse_nxt;
      skb_r    <= skb_nxt;
      kba_r    <= kba_nxt;
      ma_r     <= ma_nxt;
      tcnt_r   <= tcnt_nxt;
      trun_r   <= trun_nxt;
    end
  end

  assign out_touchpad_state  = out_item_r.touchpad_state;
  assign out_state_written   = out_item_r.state_written;
  assign out_enabled_changed = out_item_r.enabled_changed;
  assign out_notify          = out_item_r.notify;
  assign out_need_confirm    = out_item_r.need_confirm;

`ifndef SYNTHESIS
  a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r != 2'd3)
    else $error("Current state holds an unused code.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("Input refused while the output register is empty.");

  a_notify_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_notify |-> out_touchpad_state == TP_DISABLED && out_state_written)
    else $error("Notify raised without a full disable.");

  a_confirm_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_need_confirm |->
      !out_state_written && out_touchpad_state == TP_ENABLED)
    else $error("Confirmation request came with a state change.");
`endif

endmodule
